// ===== rtl/u8sd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CpW     = 31;
    localparam int unsigned LenW    = 3;
    localparam int unsigned PayW    = 7;
    localparam int unsigned ContW   = 6;
    localparam int unsigned OutDataW = 40;

    localparam logic [LenW-1:0] LenOne = 3'd1;

    typedef struct packed {
        logic [LenW-1:0] len;
        logic [PayW-1:0] payload;
    } lead_t;

endpackage : u8sd_pkg

`default_nettype wire

// ===== rtl/utf8_stream_decoder.sv =====
// UTF-8 stream decoder (1 to 6 byte sequences), top level.
//
// Input channel s_axis: one raw byte of the stream per word.
// Output channel m_axis: one decoded character per word, carrying the
// code point and the number of bytes it took.
// A lead byte opens a sequence; following bytes are taken as continuation
// bytes without checks and add their low 6 bits. Stray continuation bytes
// and 0xFE/0xFF met while idle are passed out as themselves, length 1.
// Throughput: one input word per cycle, sustained while m_axis_tready is high.
// The character is registered and appears on m_axis in the cycle after
// the word that completes it is accepted.
// The output register is reloaded in the same cycle it is drained, so
// s_axis_tready stays high while m_axis_tready is high. When the receiver
// stalls with a character pending, s_axis_tready drops until it is taken.
// Reset clears the sequence state and the output valid flag; the block is
// ready for input on the first cycle after reset is released.
`default_nettype none

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [ByteW-1:0]    s_axis_tdata,   // [7:0] in_byte
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OutDataW-1:0]      m_axis_tdata    // [30:0] code_point, [33:31] seq_length
);

    logic [CpW-1:0]  accum_reg, accum_next;
    logic [LenW-1:0] left_reg, left_next;
    logic [LenW-1:0] total_reg, total_next;
    logic [CpW-1:0]  cp_reg, cp_next;
    logic [LenW-1:0] len_reg, len_next;
    logic            ovalid_reg, ovalid_next;
    logic            in_acc;
    logic [CpW-1:0]  acc_shift;
    lead_t           lead;

    u8sd_lead_decode u_lead
    (
        .byte_in (s_axis_tdata),
        .lead    (lead)
    );

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign acc_shift     = {accum_reg[CpW-ContW-1:0], s_axis_tdata[ContW-1:0]};

    always_comb
    begin
        accum_next  = accum_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        cp_next     = cp_reg;
        len_next    = len_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        if (in_acc)
        begin
            if (left_reg != '0)
            begin
                left_next = left_reg - LenOne;
                if (left_reg == LenOne)
                begin
                    cp_next     = acc_shift;
                    len_next    = total_reg;
                    ovalid_next = 1'b1;
                    accum_next  = '0;
                    total_next  = '0;
                end
                else
                begin
                    accum_next = acc_shift;
                end
            end
            else if (lead.len == LenOne)
            begin
                cp_next     = {{(CpW-ByteW){1'b0}}, s_axis_tdata};
                len_next    = LenOne;
                ovalid_next = 1'b1;
            end
            else
            begin
                accum_next = {{(CpW-PayW){1'b0}}, lead.payload};
                total_next = lead.len;
                left_next  = lead.len - LenOne;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg  <= '0;
            left_reg   <= '0;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            accum_reg  <= accum_next;
            left_reg   <= left_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg  <= cp_next;
        len_reg <= len_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(OutDataW-CpW-LenW){1'b0}}, len_reg, cp_reg};

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 3'd5)
        else $error("bytes left out of range");

    a_total_above_left: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != '0) |-> (total_reg > left_reg))
        else $error("sequence total not above bytes left");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> (len_reg != '0 && len_reg <= 3'd6))
        else $error("output length out of range");

    a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && left_reg == '0 && !s_axis_tdata[ByteW-1]) |=>
            (ovalid_reg && len_reg == LenOne
             && cp_reg == {{(CpW-ByteW){1'b0}}, $past(s_axis_tdata)}))
        else $error("single byte character not emitted");

endmodule : utf8_stream_decoder

`default_nettype wire

// ===== rtl/u8sd_lead_decode.sv =====
// Lead byte classifier: sequence length and payload bits.
`default_nettype none

module u8sd_lead_decode
    import u8sd_pkg::*;
(
    input  wire logic [ByteW-1:0] byte_in,
    output lead_t                 lead
);

    always_comb
    begin
        unique case (byte_in) inside
            8'b0???????:
            begin
                lead.len     = 3'd1;
                lead.payload = byte_in[6:0];
            end
            8'b110?????:
            begin
                lead.len     = 3'd2;
                lead.payload = {2'b00, byte_in[4:0]};
            end
            8'b1110????:
            begin
                lead.len     = 3'd3;
                lead.payload = {3'b000, byte_in[3:0]};
            end
            8'b11110???:
            begin
                lead.len     = 3'd4;
                lead.payload = {4'b0000, byte_in[2:0]};
            end
            8'b111110??:
            begin
                lead.len     = 3'd5;
                lead.payload = {5'b00000, byte_in[1:0]};
            end
            8'b1111110?:
            begin
                lead.len     = 3'd6;
                lead.payload = {6'b000000, byte_in[0]};
            end
            default:
            begin
                // stray continuation or invalid lead: pass through as itself
                lead.len     = LenOne;
                lead.payload = byte_in[6:0];
            end
        endcase
    end

endmodule : u8sd_lead_decode

`default_nettype wire
